### design/urtf_pkg.sv
// Package for the route table forwarder: item structs, table entry layout,
// operation and route codes. No dependencies.

package urtf_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    // operation codes
    localparam logic [2:0] OP_ADD        = 3'd0;
    localparam logic [2:0] OP_LOOKUP_ALL = 3'd1;
    localparam logic [2:0] OP_LOOKUP_STK = 3'd2;
    localparam logic [2:0] OP_LOOKUP_EXT = 3'd3;
    localparam logic [2:0] OP_FORWARD    = 3'd4;

    // route kinds
    localparam logic [1:0] ROUTE_NONE  = 2'd0;
    localparam logic [1:0] ROUTE_STACK = 2'd1;
    localparam logic [1:0] ROUTE_EXT1  = 2'd2;
    localparam logic [1:0] ROUTE_EXT2  = 2'd3;

    // arrival links
    localparam logic [1:0] LINK_USB  = 2'd0;
    localparam logic [1:0] LINK_ETH  = 2'd1;
    localparam logic [1:0] LINK_WIFI = 2'd2;

    // reserved IDs
    localparam logic [31:0] UID_BROADCAST = 32'd0;
    localparam logic [31:0] UID_DAEMON    = 32'd1;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] uid;
        logic [1:0]  new_route_kind;
        logic [7:0]  new_route_option;
        logic [1:0]  source_link;
    } t_in_item;

    typedef struct packed {
        logic [1:0] route_kind;
        logic [7:0] route_option;
        logic       added;
        logic       to_all_stack;
        logic [7:0] slave_addr;
        logic       to_ext0;
        logic       to_ext1;
        logic       to_host_daemon;
    } t_out_item;

    typedef struct packed {
        logic [31:0] uid;
        logic [1:0]  kind;
        logic [7:0]  option;
    } t_entry;

    // search engine status back to the controller
    typedef struct packed {
        logic       done;
        logic       hit;
        logic [1:0] kind;
        logic [7:0] option;
    } t_srch_res;

endpackage

### design/urtf_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.

module urtf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/urtf_search.sv
// First-match scan over a range of the route table, one entry per cycle.
// Depends on urtf_pkg; drives the read port of the table RAM.

module urtf_search #(
    parameter int TABLE_DEPTH = urtf_pkg::TABLE_DEPTH_DEF,
    parameter int CW = $clog2(TABLE_DEPTH + 1),
    parameter int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [CW-1:0]       i_lo,
    input  logic [CW-1:0]       i_hi,
    input  logic [31:0]         i_uid,
    output logic [AW-1:0]       o_rd_addr,
    input  urtf_pkg::t_entry    i_rd_data,
    output urtf_pkg::t_srch_res o_res
);
    import urtf_pkg::*;

    logic          r_busy, n_busy;
    logic          r_pend, n_pend;   // read data for the previous address is valid
    logic [CW-1:0] r_addr, n_addr;
    logic [CW-1:0] r_hi,   n_hi;
    logic [31:0]   r_uid,  n_uid;
    t_srch_res     res;

    always_comb begin
        n_busy = r_busy;
        n_pend = r_pend;
        n_addr = r_addr;
        n_hi   = r_hi;
        n_uid  = r_uid;
        res    = '0;
        if (r_busy) begin
            if (r_pend && (i_rd_data.uid == r_uid)) begin
                res.done   = 1'b1;
                res.hit    = 1'b1;
                res.kind   = i_rd_data.kind;
                res.option = i_rd_data.option;
                n_busy     = 1'b0;
                n_pend     = 1'b0;
            end else if (!r_pend && (r_addr >= r_hi)) begin
                res.done = 1'b1;
                n_busy   = 1'b0;
            end else begin
                n_pend = (r_addr < r_hi);
                if (r_addr < r_hi) begin
                    n_addr = r_addr + 1'b1;
                end
            end
        end
        if (i_start) begin
            n_busy = 1'b1;
            n_pend = 1'b0;
            n_addr = i_lo;
            n_hi   = i_hi;
            n_uid  = i_uid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_pend <= n_pend;
        end
        r_addr <= n_addr;
        r_hi   <= n_hi;
        r_uid  <= n_uid;
    end

    // past the last entry the address may wrap; that read is never compared
    assign o_rd_addr = r_addr[AW-1:0];
    assign o_res     = res;

endmodule

### design/uid_route_table_forwarder_core.sv
// Top level of the route table forwarder: command port, config registers,
// forwarding decisions. Depends on urtf_pkg, urtf_ram and urtf_search.
//
//  port group            | dir | transfer condition
//  ----------------------+-----+-----------------------------------------
//  start / i_item        | in  | start high and busy low at clock edge
//  i_cfg_* / o_cfg_ready | in  | i_cfg_valid and o_cfg_ready high
//  o_res_valid / o_res   | out | o_res_valid high, one cycle, no backpressure
//
// Add, unknown operations and forwards of ID 0 or 1 give their result the
// cycle after the transfer. Lookups and routed forwards scan the table RAM one
// entry per cycle and stop at the first matching entry or at the end of their
// range. busy stays high for the whole scan.
// Reset clears the entry count and stack boundary; the RAM needs no clearing.
// Config is always ready.

module uid_route_table_forwarder_core #(
    parameter int TABLE_DEPTH = urtf_pkg::TABLE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  urtf_pkg::t_in_item i_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [3:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    output logic               o_res_valid,
    output urtf_pkg::t_out_item o_res
);
    import urtf_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int EW = $bits(t_entry);

    localparam logic [3:0] CFG_STACK_COUNT = 4'd0;
    localparam logic [3:0] CFG_EXT0_MASTER = 4'd1;
    localparam logic [3:0] CFG_EXT1_MASTER = 4'd2;
    localparam logic [3:0] CFG_MASTER_MODE = 4'd3;

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_SEARCH = 1'b1;

    logic          r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_stk_bnd, n_stk_bnd;
    logic          r_ext0_master, r_ext1_master, r_master_mode;
    logic          r_fwd, n_fwd;
    t_out_item     r_res, n_res;
    logic          r_res_vld, n_res_vld;

    logic          accept;
    logic          srch_start;
    logic [CW-1:0] srch_lo, srch_hi;
    logic [AW-1:0] rd_addr;
    logic [EW-1:0] rd_data;
    t_entry        wr_entry;
    logic          wr_en;
    t_srch_res     srch_res;

    assign accept      = start && !busy;
    assign busy        = (r_state == S_SEARCH);
    assign o_cfg_ready = 1'b1;

    assign wr_entry.uid    = i_item.uid;
    assign wr_entry.kind   = i_item.new_route_kind;
    assign wr_entry.option = i_item.new_route_option;
    assign wr_en = accept && (i_item.operation == OP_ADD) &&
                   (r_count < CW'(TABLE_DEPTH));

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_stk_bnd  = r_stk_bnd;
        n_fwd      = r_fwd;
        n_res      = r_res;
        n_res_vld  = 1'b0;
        srch_start = 1'b0;
        srch_lo    = '0;
        srch_hi    = r_count;

        if (accept) begin
            n_res = '0;
            case (i_item.operation)
                OP_ADD: begin
                    n_res_vld = 1'b1;
                    if (wr_en) begin
                        n_count   = r_count + 1'b1;
                        n_res.added = 1'b1;
                        if (i_item.new_route_kind == ROUTE_STACK) begin
                            n_stk_bnd = r_count + 1'b1;
                        end
                    end
                end
                OP_LOOKUP_ALL: begin
                    srch_start = 1'b1;
                    n_fwd      = 1'b0;
                end
                OP_LOOKUP_STK: begin
                    srch_start = 1'b1;
                    srch_hi    = r_stk_bnd;
                    n_fwd      = 1'b0;
                end
                OP_LOOKUP_EXT: begin
                    srch_start = 1'b1;
                    srch_lo    = r_stk_bnd;
                    n_fwd      = 1'b0;
                end
                OP_FORWARD: begin
                    if (i_item.uid == UID_BROADCAST) begin
                        n_res_vld          = 1'b1;
                        n_res.to_all_stack = 1'b1;
                        n_res.to_ext0      = r_ext0_master;
                        n_res.to_ext1      = r_ext1_master;
                    end else if (i_item.uid == UID_DAEMON) begin
                        n_res_vld            = 1'b1;
                        n_res.to_host_daemon = (i_item.source_link == LINK_ETH) ||
                                               (i_item.source_link == LINK_WIFI);
                    end else begin
                        srch_start = 1'b1;
                        n_fwd      = 1'b1;
                    end
                end
                default: begin
                    n_res_vld = 1'b1;
                end
            endcase
            if (srch_start) begin
                n_state = S_SEARCH;
            end
        end

        if ((r_state == S_SEARCH) && srch_res.done) begin
            n_state            = S_IDLE;
            n_res_vld          = 1'b1;
            n_res              = '0;
            n_res.route_kind   = srch_res.kind;
            n_res.route_option = srch_res.option;
            if (r_fwd) begin
                if (srch_res.kind == ROUTE_STACK) begin
                    n_res.slave_addr = srch_res.option;
                end else if (r_master_mode) begin
                    case (srch_res.kind)
                        ROUTE_EXT1: n_res.to_ext0 = r_ext0_master;
                        ROUTE_EXT2: n_res.to_ext1 = r_ext1_master;
                        default: begin
                            // miss or kind none: both master extensions
                            n_res.to_ext0 = r_ext0_master;
                            n_res.to_ext1 = r_ext1_master;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state             <= S_IDLE;
            r_count             <= '0;
            r_stk_bnd           <= '0;
            r_res_vld           <= 1'b0;
            r_ext0_master       <= 1'b0;
            r_ext1_master       <= 1'b0;
            r_master_mode       <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_stk_bnd <= n_stk_bnd;
            r_res_vld <= n_res_vld;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    // slave count only matters to the broadcast fan-out
                    // outside this block; no decision here depends on it
                    CFG_STACK_COUNT: begin
                    end
                    CFG_EXT0_MASTER: r_ext0_master       <= i_cfg_data[0];
                    CFG_EXT1_MASTER: r_ext1_master       <= i_cfg_data[0];
                    CFG_MASTER_MODE: r_master_mode       <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
        r_fwd <= n_fwd;
        r_res <= n_res;
    end

    urtf_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (wr_entry),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    urtf_search #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .CW          (CW),
        .AW          (AW)
    ) u_search (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (srch_start),
        .i_lo      (srch_lo),
        .i_hi      (srch_hi),
        .i_uid     (i_item.uid),
        .o_rd_addr (rd_addr),
        .i_rd_data (t_entry'(rd_data)),
        .o_res     (srch_res)
    );

    assign o_res_valid = r_res_vld;
    assign o_res       = r_res;

endmodule
